@@ rtl/swm_pkg.sv @@
// swm_pkg: shared constants and types of the sliding window median unit
// used by the stream interfaces, the sorting cell and the top level
`default_nettype none

package swm_pkg;

    localparam int MAX_WINDOW_DEF  = 64;
    localparam int SAMPLE_BITS_DEF = 32;

    // configuration port
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int WS_W       = 7;

    localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE = CFG_ADDR_W'(0);
    localparam logic [WS_W-1:0]       WS_RESET         = WS_W'(3);

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic load;       // input transaction taken this cycle
        logic clear;      // configuration write empties the window
        logic seq_start;  // sample starts a new sequence
        logic full;       // window full before this sample, start applied
    } t_cell_ctl;

    // per cell status seen by both neighbors
    typedef struct packed {
        logic valid;  // holds a sample of the current sequence
        logic surv;   // stays in the window after this sample
        logic lt;     // sorts before the new sample
        logic rb;     // the evicted entry sorts before this one
    } t_cell_flags;

endpackage

`default_nettype wire

@@ rtl/swm_in_if.sv @@
// swm_in_if: input stream of the median unit, valid/ready with sample and start flag
// depends on swm_pkg for the default sample width
`default_nettype none

interface swm_in_if
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          start_req;

    modport source (output valid, output sample, output start_req, input ready);
    modport sink   (input valid, input sample, input start_req, output ready);
endinterface

`default_nettype wire

@@ rtl/swm_out_if.sv @@
// swm_out_if: result stream of the median unit, valid/ready with the median value
// depends on swm_pkg for the default sample width
`default_nettype none

interface swm_out_if
    import swm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] median;

    modport source (output valid, output median, input ready);
    modport sink   (input valid, input median, output ready);
endinterface

`default_nettype wire

@@ rtl/sliding_window_median_unit.sv @@
// sliding_window_median_unit: lower median over a sliding window of signed samples
// built from swm_cell chain; depends on swm_pkg, swm_in_if, swm_out_if
//
// usage:
//   i_in carries sample and start_req; a transaction takes place when valid and
//   ready are both high. start_req empties the window before its sample.
//   o_out carries the lower median, rank (window_size+1)/2 from the smallest,
//   one transaction per sample that leaves the window full; the first
//   window_size-1 samples of a sequence give none.
//   window_size is written over the APB port at address 0; a write also empties
//   the window. sizes of 0 act as 1, sizes above MAX_WINDOW act as MAX_WINDOW.
// timing:
//   one sample per cycle while i_in.ready is high; every cell of the chain moves
//   its entry at most one place per sample, so the whole sorted window updates
//   at once. the median is registered first in the cell chain, then in the
//   output register.
// reset and stall:
//   reset empties the window and sets window_size to 3. while the receiver
//   stalls the result waits in the output register; one more sample is taken
//   and held as pending result, then i_in.ready drops until o_out is taken.
`default_nettype none

module sliding_window_median_unit
    import swm_pkg::*;
#(
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    swm_in_if.sink                i_in,
    swm_out_if.source             o_out,
    input  wire                   psel,
    input  wire                   penable,
    input  wire                   pwrite,
    input  wire [CFG_ADDR_W-1:0]  paddr,
    input  wire [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
    localparam int AGE_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIDE_W = (CNT_W > WS_W) ? CNT_W : WS_W;
    localparam logic [SAMPLE_BITS-1:0] SIGN_FLIP = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // configuration
    logic [WS_W-1:0] r_ws;
    logic            cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_SIZE);
    assign prdata = (paddr == ADDR_WINDOW_SIZE) ? APB_DATA_W'(r_ws) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws <= WS_RESET;
        end else if (cfg_wr) begin
            r_ws <= pwdata[WS_W-1:0];
        end
    end

    logic [WIDE_W-1:0] ws_wide;
    logic [CNT_W-1:0]  w_eff;
    logic [AGE_W-1:0]  age_max;
    logic [AGE_W-1:0]  rank;

    always_comb begin
        ws_wide = WIDE_W'(r_ws);
        if (ws_wide == '0) begin
            w_eff = CNT_W'(1);
        end else if (ws_wide > WIDE_W'(MAX_WINDOW)) begin
            w_eff = CNT_W'(MAX_WINDOW);
        end else begin
            w_eff = CNT_W'(ws_wide);
        end
    end

    assign age_max = AGE_W'(w_eff - CNT_W'(1));
    assign rank    = AGE_W'((w_eff - CNT_W'(1)) >> 1);

    // handshake and fill count
    logic                   r_pend, n_pend;
    logic                   r_ovalid;
    logic [SAMPLE_BITS-1:0] r_omedian;
    logic [CNT_W-1:0]       r_fill, n_fill, fill_base;
    logic                   load, move, full_now;

    assign move       = r_pend && (!r_ovalid || o_out.ready);
    assign i_in.ready = !r_pend || move;
    assign load       = i_in.valid && i_in.ready;

    assign fill_base = i_in.start_req ? '0 : r_fill;
    assign full_now  = !i_in.start_req && (r_fill == w_eff);
    assign n_fill    = (fill_base < w_eff) ? fill_base + CNT_W'(1) : fill_base;

    always_comb begin
        n_pend = r_pend;
        if (load) begin
            n_pend = (n_fill == w_eff);
        end else if (move) begin
            n_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_wr) begin
            r_fill <= '0;
        end else if (load) begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_pend <= n_pend;
            if (move) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // cell chain
    t_cell_ctl              ctl;
    logic [SAMPLE_BITS-1:0] new_key, ev_key;
    t_cell_flags            c_flags [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0] c_key   [MAX_WINDOW];
    logic [AGE_W-1:0]       c_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0]  c_valid;
    logic [MAX_WINDOW-1:0]  c_evict;

    // signed order becomes unsigned order once the sign bit is flipped
    assign new_key = SAMPLE_BITS'(i_in.sample) ^ SIGN_FLIP;
    assign ctl     = '{load: load, clear: cfg_wr, seq_start: i_in.start_req,
                       full: full_now};

    always_comb begin
        ev_key = '0;
        for (int j = 0; j < MAX_WINDOW; j++) begin
            ev_key = ev_key | (c_key[j] & {SAMPLE_BITS{c_evict[j]}});
        end
    end

    for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
        t_cell_flags            lo_flags, hi_flags;
        logic [SAMPLE_BITS-1:0] lo_key, hi_key;
        logic [AGE_W-1:0]       lo_age, hi_age;

        if (g == 0) begin : g_lo_edge
            // bottom slot fills first while the window grows
            assign lo_flags = '{valid: 1'b1, surv: 1'b0, lt: 1'b0, rb: 1'b0};
            assign lo_key   = '0;
            assign lo_age   = '0;
        end else begin : g_lo_link
            assign lo_flags = c_flags[g-1];
            assign lo_key   = c_key[g-1];
            assign lo_age   = c_age[g-1];
        end

        if (g == MAX_WINDOW - 1) begin : g_hi_edge
            assign hi_flags = '{valid: 1'b0, surv: 1'b0, lt: 1'b0, rb: 1'b0};
            assign hi_key   = '0;
            assign hi_age   = '0;
        end else begin : g_hi_link
            assign hi_flags = c_flags[g+1];
            assign hi_key   = c_key[g+1];
            assign hi_age   = c_age[g+1];
        end

        swm_cell #(
            .KEY_W (SAMPLE_BITS),
            .AGE_W (AGE_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_new_key  (new_key),
            .i_ev_key   (ev_key),
            .i_age_max  (age_max),
            .i_lo_flags (lo_flags),
            .i_lo_key   (lo_key),
            .i_lo_age   (lo_age),
            .i_hi_flags (hi_flags),
            .i_hi_key   (hi_key),
            .i_hi_age   (hi_age),
            .o_flags    (c_flags[g]),
            .o_key      (c_key[g]),
            .o_age      (c_age[g]),
            .o_valid    (c_valid[g]),
            .o_evict    (c_evict[g])
        );
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_omedian <= c_key[rank] ^ SIGN_FLIP;
        end
    end

    assign o_out.valid  = r_ovalid;
    assign o_out.median = $signed(r_omedian);

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= w_eff)
        else $error("fill count above window size");

    a_fill_cells: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(c_valid) == int'(r_fill))
        else $error("occupied cells differ from fill count");

    a_one_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(c_evict))
        else $error("more than one cell evicted");

    a_full_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full_now |-> $onehot(c_evict))
        else $error("full window without an oldest entry");

endmodule

`default_nettype wire

@@ rtl/swm_cell.sv @@
// swm_cell: one slot of the sorted window, holds a key and its age
// moves its entry up or down by at most one place each sample; depends on swm_pkg
`default_nettype none

module swm_cell
    import swm_pkg::*;
#(
    parameter int KEY_W = SAMPLE_BITS_DEF,
    parameter int AGE_W = 6
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire t_cell_ctl   i_ctl,
    input  wire [KEY_W-1:0]  i_new_key,
    input  wire [KEY_W-1:0]  i_ev_key,
    input  wire [AGE_W-1:0]  i_age_max,
    input  wire t_cell_flags i_lo_flags,
    input  wire [KEY_W-1:0]  i_lo_key,
    input  wire [AGE_W-1:0]  i_lo_age,
    input  wire t_cell_flags i_hi_flags,
    input  wire [KEY_W-1:0]  i_hi_key,
    input  wire [AGE_W-1:0]  i_hi_age,
    output t_cell_flags      o_flags,
    output logic [KEY_W-1:0] o_key,
    output logic [AGE_W-1:0] o_age,
    output logic             o_valid,
    output logic             o_evict
);

    logic             r_valid, n_valid;
    logic [KEY_W-1:0] r_key, n_key;
    logic [AGE_W-1:0] r_age, n_age;

    logic valid_e, evict, surv, lt, rb;
    logic stay, from_lo, from_hi;

    assign valid_e = r_valid && !i_ctl.seq_start;
    assign evict   = i_ctl.full && valid_e && (r_age == i_age_max);
    assign surv    = valid_e && !evict;
    assign lt      = surv && (r_key <= i_new_key);
    // the oldest entry sits first among equal keys
    assign rb      = surv && i_ctl.full && (i_ev_key <= r_key);

    assign o_flags = '{valid: valid_e, surv: surv, lt: lt, rb: rb};
    assign o_key   = r_key;
    assign o_age   = r_age;
    assign o_valid = r_valid;
    assign o_evict = evict;

    // net shift of an entry: one up if it sorts after the new key, one down
    // if the evicted entry sat below it
    assign stay    = surv && (lt != rb);
    assign from_lo = i_lo_flags.surv && !i_lo_flags.lt && !i_lo_flags.rb;
    assign from_hi = i_hi_flags.surv && i_hi_flags.lt && i_hi_flags.rb;

    always_comb begin
        n_valid = i_ctl.full ? valid_e : (valid_e || i_lo_flags.valid);
        if (stay) begin
            n_key = r_key;
            n_age = r_age + AGE_W'(1);
        end else if (from_lo) begin
            n_key = i_lo_key;
            n_age = i_lo_age + AGE_W'(1);
        end else if (from_hi) begin
            n_key = i_hi_key;
            n_age = i_hi_age + AGE_W'(1);
        end else begin
            n_key = i_new_key;
            n_age = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load) begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key <= n_key;
            r_age <= n_age;
        end
    end

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// tb: self-checking bench for sliding_window_median_unit, streams signed samples and
// checks each lower median against a sorted-window predictor held in a scoreboard class
// depends on swm_pkg, swm_in_if, swm_out_if and the unit itself
`default_nettype none

module tb
    import swm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [SAMPLE_BITS_DEF-1:0] t_sample;

    localparam int ITEMS_PER_PHASE = 106;
    localparam int NUM_PHASES      = 12;
    localparam int RANDOM_PHASE    = 9;
    localparam int HOLD_PHASE      = 8;
    localparam int PAUSE_PHASE     = 3;
    localparam int LONG_HOLD       = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_DIRECTED    = 19;

    // window sizes per phase; zero acts as one, above the capacity saturates
    localparam bit [WS_W-1:0] PHASE_SIZES [NUM_PHASES] =
        '{7'd0, 7'd1, 7'd2, 7'd64, 7'd127, 7'd65, 7'd3, 7'd3, 7'd5, 7'd0, 7'd63, 7'd4};

    localparam t_sample DIRECTED_SAMPLES [NUM_DIRECTED] = '{
        32'h7fff_ffff, 32'h8000_0000, 32'sd0, -32'sd1, 32'sd1,
        32'sd5, 32'sd5, 32'sd5, 32'sd5, -32'sd7,
        32'sd3, 32'sd3, 32'sd9, 32'sd8, 32'sd8, 32'sd8,
        32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    localparam bit DIRECTED_STARTS [NUM_DIRECTED] =
        '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0};

    class t_median_tracker;
        t_sample           expected_medians[$];
        t_sample           arrival_ring[MAX_WINDOW_DEF];
        t_sample           ordered[$];
        bit [WS_W-1:0]     window_raw     = WS_RESET;
        int unsigned       fill_count     = 0;
        int unsigned       oldest_slot    = 0;
        int unsigned       mismatch_count = 0;

        function int unsigned effective_window();
            if (window_raw == 0) return 1;
            if (window_raw > MAX_WINDOW_DEF) return MAX_WINDOW_DEF;
            return window_raw;
        endfunction

        function void restart();
            fill_count  = 0;
            oldest_slot = 0;
            ordered.delete();
        endfunction

        function void set_window(bit [WS_W-1:0] raw);
            window_raw = raw;
            restart();
        endfunction

        function int pending();
            return expected_medians.size();
        endfunction

        function void flag(string what, longint exp, longint act);
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("mismatch on %s: expected %0d, got %0d", what, exp, act);
        endfunction

        // window update for one input transaction
        function void take_sample(t_sample s, bit start);
            int unsigned w;
            int unsigned slot;
            int          pos;
            t_sample     old;
            w = effective_window();
            if (start) restart();
            if (fill_count < w) begin
                arrival_ring[fill_count] = s;
                fill_count++;
                oldest_slot = 0;
            end else begin
                slot = oldest_slot % w;
                old = arrival_ring[slot];
                arrival_ring[slot] = s;
                oldest_slot = (slot + 1) % w;
                // only one copy of an equal value leaves
                pos = 0;
                while (ordered[pos] != old) pos++;
                ordered.delete(pos);
            end
            pos = 0;
            while (pos < ordered.size() && ordered[pos] <= s) pos++;
            ordered.insert(pos, s);
            if (fill_count >= w)
                expected_medians.push_back(ordered[(w + 1) / 2 - 1]);
        endfunction

        function void match_median(t_sample actual);
            t_sample exp;
            if (expected_medians.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("mismatch: median %0d with nothing outstanding", actual);
            end else begin
                exp = expected_medians.pop_front();
                if (exp !== actual) flag("median", exp, actual);
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bit calm           = 0;
    bit long_hold_req  = 0;

    t_median_tracker tracker = new();

    swm_in_if  #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) in_if ();
    swm_out_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) out_if ();

    sliding_window_median_unit #(
        .MAX_WINDOW  (MAX_WINDOW_DEF),
        .SAMPLE_BITS (SAMPLE_BITS_DEF)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // one sample transaction, with an optional idle burst before it
    task automatic push_sample(t_sample s, bit start);
        if (!calm && $urandom_range(0, 7) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.sample    <= s;
        in_if.start_req <= start;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
    endtask

    // stop sending and wait until every median has come out
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_window(bit [WS_W-1:0] raw);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_WINDOW_SIZE;
        pwdata  <= APB_DATA_W'(raw);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        // read back right after, psel stays high for the setup cycle
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[WS_W-1:0] !== raw)
            tracker.flag("window_size readback", raw, prdata[WS_W-1:0]);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver: random stalls, one long hold-off on request
    initial begin
        out_if.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (long_hold_req) begin
                out_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_req = 0;
            end else if (!calm && $urandom_range(0, 9) == 0) begin
                out_if.ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end else begin
                out_if.ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end
        end
    end

    // monitor: feeds the predictor, checks results, watches for a hang
    initial begin
        int unsigned quiet_cycles;
        bit          moved;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            moved = 1'b0;
            if (psel && penable && pwrite && pready) begin
                tracker.set_window(pwdata[WS_W-1:0]);
                moved = 1'b1;
            end
            if (i_rst_n && in_if.valid && in_if.ready) begin
                tracker.take_sample(in_if.sample, in_if.start_req);
                moved = 1'b1;
            end
            if (i_rst_n && out_if.valid && out_if.ready) begin
                tracker.match_median(out_if.median);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        t_sample         s;
        bit              start;
        int unsigned     w;
        bit [WS_W-1:0]   raw;
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.sample    <= '0;
        in_if.start_req <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset window of three: extremes, duplicates, restarts when full and when filling
        for (int i = 0; i < NUM_DIRECTED; i++)
            push_sample(DIRECTED_SAMPLES[i], DIRECTED_STARTS[i]);
        settle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            raw = (ph == RANDOM_PHASE) ? WS_W'($urandom_range(0, 127)) : PHASE_SIZES[ph];
            program_window(raw);
            calm = (ph == NUM_PHASES - 1);
            w = tracker.effective_window();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == HOLD_PHASE && n == 40) long_hold_req = 1;
                if (ph == PAUSE_PHASE && n == 70) settle();
                // restarts kept rare so most sequences fill the window
                start = ($urandom_range(0, 3 * w + 8) == 0);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: s = t_sample'($urandom);
                    4, 5, 6, 7: s = t_sample'($urandom_range(0, 8)) - 4;
                    8:          s = 32'h8000_0000 + t_sample'($urandom_range(0, 3));
                    default:    s = 32'h7fff_ffff - t_sample'($urandom_range(0, 3));
                endcase
                push_sample(s, start);
            end
            settle();
        end

        if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/swm_pkg.sv
rtl/swm_in_if.sv
rtl/swm_out_if.sv
rtl/swm_cell.sv
rtl/sliding_window_median_unit.sv
tb/tb.sv
